### rtl/sat_pkg.sv
`default_nettype none
package sat_pkg;
  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 2048;
  localparam int MAX_DEGREE = 32;
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int DPW = $clog2(MAX_DEGREE);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int RLW = RW + DPW;
  localparam int CLW = CW + DPW;

  localparam logic [0:0] CFG_ROWS = 1'b0;
  localparam logic [0:0] CFG_COLS = 1'b1;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_COL_RANGE = 3'd1,
    ST_ROW_RANGE = 3'd2,
    ST_DUP_ROW = 3'd3,
    ST_DUP_COL = 3'd4,
    ST_ABSENT = 3'd5,
    ST_ONE_SIDED = 3'd6,
    ST_FULL = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEG,
    S_SCAN,
    S_LAST,
    S_WRITE,
    S_PEAK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic read_deg;
    logic scan_start;
    logic scan_step;
    logic read_last;
    logic commit;
    logic peak;
    logic out_valid;
  } ctl_t;

  typedef struct packed {
    logic clear_done;
    logic range_bad;
    logic scan_done;
    logic out_taken;
  } sts_t;
endpackage
`default_nettype wire

### rtl/sat_if.sv
`default_nettype none
interface sat_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [sat_pkg::RW-1:0] row_sel;
  logic [sat_pkg::CW-1:0] col_sel;
  modport source(output valid, cmd, row_sel, col_sel, input ready);
  modport sink(input valid, cmd, row_sel, col_sel, output ready);
endinterface

interface sat_out_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [5:0] max_row_degree;
  logic [5:0] max_col_degree;
  logic [15:0] connection_total;
  modport source(output valid, status, max_row_degree, max_col_degree,
    connection_total, input ready);
  modport sink(input valid, status, max_row_degree, max_col_degree,
    connection_total, output ready);
endinterface

interface sat_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [11:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/sat_ctrl.sv
`default_nettype none
module sat_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire sat_pkg::sts_t sts,
  output sat_pkg::ctl_t ctl,
  output logic idle
);
  import sat_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (sts.clear_done) state_next = S_IDLE;
      S_IDLE: if (in_fire) state_next = S_DEG;
      S_DEG: state_next = sts.range_bad ? S_OUT : S_SCAN;
      S_SCAN: if (sts.scan_done) state_next = S_LAST;
      S_LAST: state_next = S_WRITE;
      S_WRITE: state_next = S_PEAK;
      S_PEAK: state_next = S_OUT;
      S_OUT: if (sts.out_taken) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    idle = 1'b0;
    case (state)
      S_CLEAR: ctl.clear = 1'b1;
      S_IDLE: begin
        idle = 1'b1;
        ctl.load = in_fire;
      end
      S_DEG: begin
        ctl.read_deg = 1'b1;
        ctl.scan_start = !sts.range_bad;
      end
      S_SCAN: ctl.scan_step = 1'b1;
      S_LAST: ctl.read_last = 1'b1;
      S_WRITE: ctl.commit = 1'b1;
      S_PEAK: ctl.peak = 1'b1;
      S_OUT: ctl.out_valid = 1'b1;
      default: ctl = '0;
    endcase
  end
endmodule
`default_nettype wire

### rtl/sat_dp.sv
`default_nettype none
module sat_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sat_pkg::ctl_t ctl,
  output sat_pkg::sts_t sts,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic in_cmd,
  input  wire logic [sat_pkg::RW-1:0] in_row,
  input  wire logic [sat_pkg::CW-1:0] in_col,
  input  wire logic out_ready,
  output logic [2:0] status,
  output logic [5:0] max_row_degree,
  output logic [5:0] max_col_degree,
  output logic [15:0] connection_total
);
  import sat_pkg::*;

  logic [CW-1:0] clist_r [MAX_ROWS*MAX_DEGREE];
  logic [RW-1:0] clist [MAX_COLS*MAX_DEGREE];
  logic [DW-1:0] rdeg_mem [MAX_ROWS];
  logic [DW-1:0] cdeg_mem [MAX_COLS];
  logic [RW:0] rhist [MAX_DEGREE+1];
  logic [CW:0] chist [MAX_DEGREE+1];

  logic [10:0] rows_in_use;
  logic [11:0] cols_in_use;
  logic cmd;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [DW-1:0] rd, cd, rdq, cdq;
  logic [DW-1:0] idx;
  logic rq_ok;
  logic [DW-1:0] rpos, cpos;
  logic rfound, cfound;
  logic [CW-1:0] rlast;
  logic [RW-1:0] clast;
  logic [2:0] st;
  logic [DW-1:0] rpk, cpk;
  logic [15:0] links;
  logic range_bad;
  logic [DW-1:0] rnew, cnew;
  logic do_r, do_c, chk;
  logic [CW-1:0] clr_idx;
  logic [RW:0] rh_a, rh_b;
  logic [CW:0] ch_a, ch_b;

  assign range_bad = ({1'b0, in_col} >= cols_in_use[CW:0]) ||
    ({1'b0, in_row} >= rows_in_use);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 11'(MAX_ROWS);
      cols_in_use <= 12'(MAX_COLS);
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROWS) rows_in_use <= cfg_data[10:0];
      else cols_in_use <= cfg_data;
    end
  end

  // clearing pass over the degree memories and histograms
  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (ctl.clear) clr_idx <= clr_idx + 1'b1;
  end

  assign sts.clear_done = (clr_idx == CW'(MAX_COLS - 1));

  logic bad_q;
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= in_cmd;
      row <= in_row;
      col <= in_col;
      bad_q <= range_bad;
      if ({1'b0, in_col} >= cols_in_use[CW:0]) st <= ST_COL_RANGE;
      else if ({1'b0, in_row} >= rows_in_use) st <= ST_ROW_RANGE;
      else st <= ST_OK;
    end else if (ctl.commit) begin
      if (cmd == CMD_ADD) begin
        if (rf_l) st <= ST_DUP_ROW;
        else if (cf_l) st <= ST_DUP_COL;
        else if (!do_r) st <= ST_FULL;
      end else begin
        if (rf_l != cf_l) st <= ST_ONE_SIDED;
        else if (!rf_l) st <= ST_ABSENT;
      end
    end
    rdq <= rdeg_mem[in_row];
    cdq <= cdeg_mem[in_col];
    if (ctl.read_deg) begin
      rd <= rdq;
      cd <= cdq;
    end
  end

  assign sts.range_bad = bad_q;
  assign chk = idx < rd || idx < cd;
  assign sts.scan_done = !chk;
  assign sts.out_taken = ctl.out_valid && out_ready;

  logic [CW-1:0] rq_d;
  logic [RW-1:0] cq_d;
  logic [DPW-1:0] ip;
  assign ip = idx[DPW-1:0];
  always_ff @(posedge clk) begin
    rq_d <= clist_r[{row, ip}];
    cq_d <= clist[{col, ip}];
  end

  logic [DW-1:0] pidx;
  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      idx <= '0;
      rq_ok <= 1'b0;
      rfound <= 1'b0;
      cfound <= 1'b0;
    end else if (ctl.scan_step) begin
      if (chk) idx <= idx + 1'b1;
      rq_ok <= chk;
      pidx <= idx;
      if (rq_ok) begin
        if (pidx < rd && rq_d == col && !rfound) begin
          rfound <= 1'b1;
          rpos <= pidx;
        end
        if (pidx < cd && cq_d == row && !cfound) begin
          cfound <= 1'b1;
          cpos <= pidx;
        end
      end
    end
  end

  logic [DPW-1:0] rlp, clp;
  assign rlp = DPW'(rd - 1'b1);
  assign clp = DPW'(cd - 1'b1);
  always_ff @(posedge clk) begin
    if (ctl.read_last) begin
      rlast <= clist_r[{row, rlp}];
      clast <= clist[{col, clp}];
      rh_a <= rhist[rd];
      rh_b <= rhist[rnew];
      ch_a <= chist[cd];
      ch_b <= chist[cnew];
    end
  end

  logic rf, cf;
  always_comb begin
    rf = rfound;
    cf = cfound;
    if (rq_ok) begin
      if (pidx < rd && rq_d == col) rf = 1'b1;
      if (pidx < cd && cq_d == row) cf = 1'b1;
    end
  end

  logic rf_l, cf_l;
  always_ff @(posedge clk) begin
    if (ctl.scan_step) begin
      rf_l <= rf;
      cf_l <= cf;
    end
  end

  assign do_r = (cmd == CMD_ADD) ? (!rf_l && !cf_l && rd < MAX_DEGREE && cd < MAX_DEGREE)
    : rf_l;
  assign do_c = (cmd == CMD_ADD) ? do_r : cf_l;
  assign rnew = (cmd == CMD_ADD) ? rd + 1'b1 : rd - 1'b1;
  assign cnew = (cmd == CMD_ADD) ? cd + 1'b1 : cd - 1'b1;

  logic [DPW-1:0] rwp, cwp;
  logic [CW-1:0] rwv;
  logic [RW-1:0] cwv;
  assign rwp = (cmd == CMD_ADD) ? rd[DPW-1:0] : rpos[DPW-1:0];
  assign cwp = (cmd == CMD_ADD) ? cd[DPW-1:0] : cpos[DPW-1:0];
  assign rwv = (cmd == CMD_ADD) ? col : rlast;
  assign cwv = (cmd == CMD_ADD) ? row : clast;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      cdeg_mem[clr_idx] <= '0;
      if (clr_idx < CW'(MAX_ROWS)) rdeg_mem[clr_idx[RW-1:0]] <= '0;
      if (clr_idx <= CW'(MAX_DEGREE)) begin
        rhist[clr_idx[DW-1:0]] <= (clr_idx == '0) ? (RW+1)'(MAX_ROWS) : '0;
        chist[clr_idx[DW-1:0]] <= (clr_idx == '0) ? (CW+1)'(MAX_COLS) : '0;
      end
    end
    if (ctl.commit && do_r) begin
      clist_r[{row, rwp}] <= rwv;
      rdeg_mem[row] <= rnew;
      rhist[rd] <= rh_a - 1'b1;
      rhist[rnew] <= rh_b + 1'b1;
    end
    if (ctl.commit && do_c) begin
      clist[{col, cwp}] <= cwv;
      cdeg_mem[col] <= cnew;
      chist[cd] <= ch_a - 1'b1;
      chist[cnew] <= ch_b + 1'b1;
    end
  end

  logic [RW:0] rh_old;
  logic [CW:0] ch_old;
  always_ff @(posedge clk) begin
    if (rst) begin
      rpk <= '0;
      cpk <= '0;
      links <= '0;
    end else begin
      if (ctl.commit) begin
        if (do_r) rh_old <= rh_a - 1'b1;
        if (do_c) ch_old <= ch_a - 1'b1;
        if (cmd == CMD_ADD) begin
          if (do_r) begin
            links <= links + 1'b1;
            if (rnew > rpk) rpk <= rnew;
            if (cnew > cpk) cpk <= cnew;
          end
        end else if (rf_l && cf_l) links <= links - 1'b1;
      end
      if (ctl.peak && cmd == CMD_REMOVE) begin
        if (do_r && rpk == rd && rh_old == '0) rpk <= rnew;
        if (do_c && cpk == cd && ch_old == '0) cpk <= cnew;
      end
    end
  end

  assign status = st;
  assign max_row_degree = 6'(rpk);
  assign max_col_degree = 6'(cpk);
  assign connection_total = links;
endmodule
`default_nettype wire

### rtl/sparse_adjacency_table_unit.sv
`default_nettype none
// channel  dir  fields
// in       in   cmd, row_sel, col_sel
// out      out  status, max_row_degree, max_col_degree, connection_total
// cfg      in   index, data
// an item steps through DEG, SCAN, LAST, WRITE, PEAK and OUT; the serial scan
// over the list memories walks max(row degree, column degree) entries; an
// index out of range goes from DEG to OUT; reset is synchronous and a clearing
// pass then zeroes the degree memories and histograms before the first word is
// taken; the next item is taken once the result word has been accepted
module sparse_adjacency_table_unit (
  input wire logic clk,
  input wire logic rst,
  sat_in_if.sink  in_ch,
  sat_out_if.source out_ch,
  sat_cfg_if.sink cfg
);
  import sat_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic idle, in_fire;

  assign in_ch.ready = idle;
  assign in_fire = in_ch.valid && idle;
  assign cfg.ready = 1'b1;
  assign out_ch.valid = ctl.out_valid;

  sat_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .sts(sts), .ctl(ctl), .idle(idle)
  );

  sat_dp u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .in_cmd(in_ch.cmd), .in_row(in_ch.row_sel), .in_col(in_ch.col_sel),
    .out_ready(out_ch.ready),
    .status(out_ch.status), .max_row_degree(out_ch.max_row_degree),
    .max_col_degree(out_ch.max_col_degree),
    .connection_total(out_ch.connection_total)
  );

`ifndef ASSERT_OFF
  a_one_job: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
    else $error("result dropped");
`endif
endmodule
`default_nettype wire
